### design/assert_macros.svh
// Assertion macros shared by the RTL of the table interpolator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tli_pkg.sv
// Package of types and constants for the table interpolator
package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;
    localparam int FIELD_W         = 32;
    localparam int INDEX_W         = 10;
    localparam int ENTRIES_W       = 11;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd1024;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t            req_type;
        logic [INDEX_W-1:0]   entry_index;
        logic [FIELD_W-1:0]   entry_radius;
        logic [FIELD_W-1:0]   entry_density;
        logic [FIELD_W-1:0]   query_radius;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   density_out;
        logic                 out_of_range;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_EMIT
    } tli_state_t;

endpackage

### design/table_linear_interpolator.sv
// Load: written when accepted in IDLE. Query: accepted in IDLE, then one table entry
// scanned per cycle up to the last entry in use, a VALUE_BITS-step bit-serial
// multiply-divide when inside a segment, then the result is registered when the output
// is free. Requests are taken only in IDLE; the scan is bounded by the single read port
// of the table memory.
// Reset (aresetn, synchronous): control cleared, entries_in_use = 1024, table undefined.
`include "assert_macros.svh"

module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = tli_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tli_pkg::ENTRIES_W-1:0]   cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tli_pkg::req_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tli_pkg::rsp_t                   m_data
);
    import tli_pkg::*;

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int DEPTH_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W     = (DEPTH_W > ENTRIES_W) ? DEPTH_W : ENTRIES_W;
    localparam int IDXC_W    = (DEPTH_W > INDEX_W) ? DEPTH_W : INDEX_W;
    localparam int VB        = VALUE_BITS;
    localparam int BITC_W    = $clog2(VALUE_BITS + 1);

    // table memory: radius in the upper half, density in the lower
    logic [2*VB-1:0] table_mem [TABLE_DEPTH];
    logic [2*VB-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    tli_state_t state_reg, state_next;
    logic [ENTRIES_W-1:0] entries_reg;

    logic [VB-1:0]     q_reg, q_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [VB-1:0]     prev_r_reg, prev_r_next;
    logic [VB-1:0]     prev_d_reg, prev_d_next;
    logic [VB-1:0]     a_reg, a_next;
    logic [VB-1:0]     t_reg, t_next;
    logic [VB-1:0]     s_reg, s_next;
    logic [VB-1:0]     quo_reg, quo_next;
    logic [VB-1:0]     rem_reg, rem_next;
    logic [BITC_W-1:0] bitc_reg, bitc_next;
    logic [VB-1:0]     d0_reg, d0_next;
    logic              neg_reg, neg_next;
    logic              flag_reg, flag_next;
    logic              m_valid_reg, m_valid_next;
    rsp_t              out_reg, out_next;

    logic              in_acc;
    logic              query_acc;
    logic [CNT_W-1:0]  cnt_ext, cnt_clamp;
    logic [VB-1:0]     cur_r, cur_d;
    logic              in_seg;
    logic              is_last;
    logic              below;
    logic [VB+1:0]     r2, r2_s1, r2_s2;
    logic              ge1, ge2;
    logic [1:0]        step_q;
    logic              out_free;

    // refuse requests and register writes while reset is held
    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign in_acc    = s_valid && s_ready;
    assign query_acc = in_acc && (s_data.req_type == REQ_QUERY);
    assign out_free  = !m_valid_reg || m_ready;

    assign cur_r   = rd_data_reg[2*VB-1:VB];
    assign cur_d   = rd_data_reg[VB-1:0];
    assign below   = (q_reg < cur_r);
    assign in_seg  = (prev_r_reg <= q_reg) && below;
    assign is_last = (idx_reg == last_reg);

    // clamp the entry count to between 2 and the table depth
    always_comb begin
        cnt_ext = CNT_W'(entries_reg);
        if (cnt_ext > CNT_W'(TABLE_DEPTH)) begin
            cnt_clamp = CNT_W'(TABLE_DEPTH);
        end else if (cnt_ext < CNT_W'(2)) begin
            cnt_clamp = CNT_W'(2);
        end else begin
            cnt_clamp = cnt_ext;
        end
    end

    // write port: loads into slots inside the table
    assign wr_en = in_acc && (s_data.req_type == REQ_LOAD)
                   && (IDXC_W'(s_data.entry_index) < IDXC_W'(TABLE_DEPTH));
    assign wr_addr = AW'(s_data.entry_index);

    // read port: entry 0 on a new request, else the entry after the one held
    assign rd_addr = (state_reg == ST_IDLE) ? '0 : AW'(idx_reg + AW'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= {VB'(s_data.entry_radius), VB'(s_data.entry_density)};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= table_mem[rd_addr];
    end

    // one step of the bit-serial multiply-divide: remainder stays below the divisor
    always_comb begin
        r2    = {1'b0, rem_reg, 1'b0} + (a_reg[VB-1] ? {2'b00, t_reg} : '0);
        r2_s1 = r2 - {2'b00, s_reg};
        r2_s2 = r2 - {1'b0, s_reg, 1'b0};
        ge2   = (r2 >= {1'b0, s_reg, 1'b0});
        ge1   = (r2 >= {2'b00, s_reg});
        if (ge2) begin
            step_q = 2'd2;
        end else if (ge1) begin
            step_q = 2'd1;
        end else begin
            step_q = 2'd0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (query_acc) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == '0) begin
                    if (below) begin
                        state_next = ST_EMIT;
                    end
                end else if (in_seg) begin
                    state_next = ST_DIVIDE;
                end else if (is_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE: begin
                if (bitc_reg == BITC_W'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        q_next       = q_reg;
        last_next    = last_reg;
        idx_next     = idx_reg;
        prev_r_next  = prev_r_reg;
        prev_d_next  = prev_d_reg;
        a_next       = a_reg;
        t_next       = t_reg;
        s_next       = s_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bitc_next    = bitc_reg;
        d0_next      = d0_reg;
        neg_next     = neg_reg;
        flag_next    = flag_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                // capture the request and the clamped last index
                if (query_acc) begin
                    q_next    = VB'(s_data.query_radius);
                    last_next = AW'(cnt_clamp - CNT_W'(1));
                    idx_next  = '0;
                end
            end
            ST_SCAN: begin
                // advance one entry, or settle on a segment or an end value
                quo_next    = '0;
                neg_next    = 1'b0;
                prev_r_next = cur_r;
                prev_d_next = cur_d;
                idx_next    = AW'(idx_reg + AW'(1));
                if (idx_reg == '0) begin
                    d0_next   = cur_d;
                    flag_next = 1'b1;
                end else if (in_seg) begin
                    d0_next   = prev_d_reg;
                    flag_next = 1'b0;
                    neg_next  = (cur_d < prev_d_reg);
                    a_next    = (cur_d < prev_d_reg) ? (prev_d_reg - cur_d)
                                                     : (cur_d - prev_d_reg);
                    t_next    = q_reg - prev_r_reg;
                    s_next    = cur_r - prev_r_reg;
                    rem_next  = '0;
                    bitc_next = BITC_W'(VB);
                end else begin
                    d0_next   = cur_d;
                    flag_next = (q_reg != cur_r);
                end
            end
            ST_DIVIDE: begin
                a_next    = {a_reg[VB-2:0], 1'b0};
                quo_next  = {quo_reg[VB-2:0], 1'b0} + VB'(step_q);
                rem_next  = ge2 ? VB'(r2_s2) : (ge1 ? VB'(r2_s1) : VB'(r2));
                bitc_next = BITC_W'(bitc_reg - BITC_W'(1));
            end
            ST_EMIT: begin
                // hold until the result register is free
                if (out_free) begin
                    out_next.density_out  = FIELD_W'(neg_reg ? (d0_reg - quo_reg)
                                                             : (d0_reg + quo_reg));
                    out_next.out_of_range = flag_reg;
                    m_valid_next          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            entries_reg <= ENTRIES_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                entries_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        q_reg      <= q_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        prev_r_reg <= prev_r_next;
        prev_d_reg <= prev_d_next;
        a_reg      <= a_next;
        t_reg      <= t_next;
        s_reg      <= s_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        bitc_reg   <= bitc_next;
        d0_reg     <= d0_next;
        neg_reg    <= neg_next;
        flag_reg   <= flag_next;
        out_reg    <= out_next;
    end

    `ASSERT_NXT(a_query_starts_scan, aclk, aresetn, query_acc, (state_reg == ST_SCAN) && (idx_reg == '0), "query did not start its scan at entry zero")
    `ASSERT_IMP(a_scan_in_table, aclk, aresetn, state_reg == ST_SCAN, idx_reg <= last_reg, "scan ran past the last entry in use")
    `ASSERT_IMP(a_rem_below_div, aclk, aresetn, state_reg == ST_DIVIDE, (rem_reg < s_reg) && (bitc_reg != '0), "divider remainder or step count out of bounds")

endmodule
